FILE: hdl/cda_pkg.sv
package cda_pkg;

	// Day count bits taken from days_to_add
	localparam int DAY_COUNT_BITS = 16;
	localparam int ADD_PORT_W = 16;
	localparam int CNT_W = (DAY_COUNT_BITS < ADD_PORT_W) ? DAY_COUNT_BITS : ADD_PORT_W;
	// Running day: 5-bit day plus count, one carry bit
	localparam int DAY_W = CNT_W + 1;

	localparam logic [13:0] YEAR_MAX = 14'd16383;
	localparam logic [4:0] MONTHS_PER_YEAR = 5'd12;

	// Month enumeration used by the length table
	localparam logic [3:0] M_JAN = 4'd1;
	localparam logic [3:0] M_FEB = 4'd2;
	localparam logic [3:0] M_MAR = 4'd3;
	localparam logic [3:0] M_APR = 4'd4;
	localparam logic [3:0] M_MAY = 4'd5;
	localparam logic [3:0] M_JUN = 4'd6;
	localparam logic [3:0] M_JUL = 4'd7;
	localparam logic [3:0] M_AUG = 4'd8;
	localparam logic [3:0] M_SEP = 4'd9;
	localparam logic [3:0] M_OCT = 4'd10;
	localparam logic [3:0] M_NOV = 4'd11;
	localparam logic [3:0] M_DEC = 4'd12;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} cda_state_t;

	// Days in a month; every fourth year is a leap year, out-of-range months are empty
	function automatic logic [4:0] month_length(input logic [3:0] month, input logic [13:0] year);
		logic [4:0] len;
		case (month)
			M_JAN, M_MAR, M_MAY, M_JUL, M_AUG, M_OCT, M_DEC: len = 5'd31;
			M_APR, M_JUN, M_SEP, M_NOV: len = 5'd30;
			M_FEB: len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

FILE: hdl/calendar_date_advance_top.sv
// Date advance: give a start date and a day count with a start pulse while busy is
// low; the block steps one month per clock through a single compare/subtract unit
// and presents the resulting date with done high for exactly one cycle. busy is
// high from the cycle after the start pulse until the result appears; the result must
// be captured on the done cycle as it cannot be held off. Years saturate at 16383 with
// year_overflow set.
module calendar_date_advance_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [4:0]  start_day,
	input  logic [3:0]  start_month,
	input  logic [13:0] start_year,
	input  logic [15:0] days_to_add,
	output logic        done,
	output logic [4:0]  end_day,
	output logic [3:0]  end_month,
	output logic [13:0] end_year,
	output logic        year_overflow
);

	cda_pkg::cda_state_t state_q;
	logic                    done_q;
	logic [cda_pkg::DAY_W-1:0] day_q;
	logic [3:0]              month_q;
	logic [13:0]             year_q;
	logic                    ovf_q;

	logic [4:0]              len;
	logic                    fits;
	logic [4:0]              month_inc;
	logic [3:0]              month_nxt;
	logic                    wrap;
	logic                    accept;

	assign accept = start && (state_q == cda_pkg::ST_IDLE);

	// Shared unit: month length, compare and next-month logic
	always_comb begin
		len = cda_pkg::month_length(month_q, year_q);
		fits = (day_q <= cda_pkg::DAY_W'(len));
		month_inc = {1'b0, month_q} + 5'd1;
		wrap = (month_inc > cda_pkg::MONTHS_PER_YEAR);
		month_nxt = wrap ? 4'(month_inc - cda_pkg::MONTHS_PER_YEAR) : month_inc[3:0];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cda_pkg::ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				cda_pkg::ST_IDLE: begin
					if (start) begin
						state_q <= cda_pkg::ST_RUN;
					end
				end
				cda_pkg::ST_RUN: begin
					if (fits) begin
						state_q <= cda_pkg::ST_IDLE;
						done_q <= 1'b1;
					end
				end
				default: begin
					state_q <= cda_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Working date registers
	always_ff @(posedge clk) begin
		if (accept) begin
			day_q <= cda_pkg::DAY_W'(start_day)
				+ cda_pkg::DAY_W'(days_to_add[cda_pkg::CNT_W-1:0]);
			month_q <= start_month;
			year_q <= start_year;
			ovf_q <= 1'b0;
		end else if ((state_q == cda_pkg::ST_RUN) && !fits) begin
			day_q <= day_q - cda_pkg::DAY_W'(len);
			month_q <= month_nxt;
			if (wrap) begin
				if (year_q == cda_pkg::YEAR_MAX) begin
					ovf_q <= 1'b1;
				end else begin
					year_q <= year_q + 14'd1;
				end
			end
		end
	end

	assign busy = (state_q == cda_pkg::ST_RUN);
	assign done = done_q;
	assign end_day = day_q[4:0];
	assign end_month = month_q;
	assign end_year = year_q;
	assign year_overflow = ovf_q;

endmodule

FILE: hdl/cda_checker.sv
module cda_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [13:0] end_year,
	input logic        year_overflow
);

	// An accepted item makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// A result ends the work on its item
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result without preceding busy period");

	// One result per item
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result repeated");

	// Overflow only with a saturated year
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && year_overflow |-> end_year == 14'd16383)
		else $error("overflow flagged with year below maximum");

endmodule

bind calendar_date_advance_top cda_checker u_cda_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.end_year(end_year),
	.year_overflow(year_overflow)
);

FILE: verif/date_advance_checker.sv
module date_advance_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [4:0]  start_day,
	input  logic [3:0]  start_month,
	input  logic [13:0] start_year,
	input  logic [15:0] days_to_add,
	input  logic        done,
	input  logic [4:0]  end_day,
	input  logic [3:0]  end_month,
	input  logic [13:0] end_year,
	input  logic        year_overflow,
	output int          pending,
	output int          errors
);

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic        ovf;
	} date_t;

	localparam int unsigned COUNT_MASK = (1 << cda_pkg::CNT_W) - 1;

	// dates still owed by the block, oldest first
	date_t expected_dates[$];
	date_t head;

	initial errors = 0;

	// month length with the every-fourth-year leap rule; bad months are empty
	function automatic int unsigned days_in_month(input int unsigned mon, input int unsigned yr);
		int unsigned days;
		case (mon)
			cda_pkg::M_JAN, cda_pkg::M_MAR, cda_pkg::M_MAY, cda_pkg::M_JUL,
			cda_pkg::M_AUG, cda_pkg::M_OCT, cda_pkg::M_DEC: days = 31;
			cda_pkg::M_APR, cda_pkg::M_JUN, cda_pkg::M_SEP, cda_pkg::M_NOV: days = 30;
			cda_pkg::M_FEB: days = (yr % 4 == 0) ? 29 : 28;
			default: days = 0;
		endcase
		return days;
	endfunction

	// date reached after the given number of days, year saturating at the top
	function automatic date_t advance_date(input logic [4:0] d, input logic [3:0] m,
			input logic [13:0] y, input logic [15:0] n);
		int unsigned run_day;
		int unsigned mon;
		int unsigned yr;
		date_t r;
		r.ovf = 1'b0;
		run_day = d + (n & COUNT_MASK);
		mon = m;
		yr = y;
		while (run_day > days_in_month(mon, yr)) begin
			run_day -= days_in_month(mon, yr);
			mon++;
			if (mon > cda_pkg::MONTHS_PER_YEAR) begin
				mon -= cda_pkg::MONTHS_PER_YEAR;
				if (yr >= cda_pkg::YEAR_MAX) begin
					yr = cda_pkg::YEAR_MAX;
					r.ovf = 1'b1;
				end else begin
					yr++;
				end
			end
		end
		r.day = run_day[4:0];
		r.month = mon[3:0];
		r.year = yr[13:0];
		return r;
	endfunction

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		errors++;
	endtask

	// queue a date per accepted item, compare each result with the oldest
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_dates.delete();
			pending <= 0;
		end else begin
			if (start && !busy)
				expected_dates.push_back(advance_date(start_day, start_month, start_year,
					days_to_add));
			if (done) begin
				if (expected_dates.size() == 0) begin
					report($sformatf("result %0d/%0d/%0d with no item outstanding",
						end_day, end_month, end_year));
				end else begin
					head = expected_dates.pop_front();
					if (end_day !== head.day)
						report($sformatf("end_day got %0d expected %0d", end_day, head.day));
					if (end_month !== head.month)
						report($sformatf("end_month got %0d expected %0d", end_month,
							head.month));
					if (end_year !== head.year)
						report($sformatf("end_year got %0d expected %0d", end_year, head.year));
					if (year_overflow !== head.ovf)
						report($sformatf("year_overflow got %0b expected %0b", year_overflow,
							head.ovf));
				end
			end
			pending <= expected_dates.size();
		end
	end

endmodule

FILE: verif/tb.sv
module tb;

	localparam int RANDOM_ITEMS = 250;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int TAIL_CYCLES = 2300;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [4:0]  start_day;
	logic [3:0]  start_month;
	logic [13:0] start_year;
	logic [15:0] days_to_add;
	logic        done;
	logic [4:0]  end_day;
	logic [3:0]  end_month;
	logic [13:0] end_year;
	logic        year_overflow;
	int          pending;
	int          errors;
	int          cycle_count;
	int          sent;
	int          burst;
	bit          drained;

	calendar_date_advance_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_day(start_day),
		.start_month(start_month),
		.start_year(start_year),
		.days_to_add(days_to_add),
		.done(done),
		.end_day(end_day),
		.end_month(end_month),
		.end_year(end_year),
		.year_overflow(year_overflow)
	);

	date_advance_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_day(start_day),
		.start_month(start_month),
		.start_year(start_year),
		.days_to_add(days_to_add),
		.done(done),
		.end_day(end_day),
		.end_month(end_month),
		.end_year(end_year),
		.year_overflow(year_overflow),
		.pending(pending),
		.errors(errors)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// present one item and hold it until the block takes it
	task automatic drive_item(input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
			input logic [15:0] n);
		start <= 1'b1;
		start_day <= d;
		start_month <= m;
		start_year <= y;
		days_to_add <= n;
		do @(posedge clk); while (busy);
	endtask

	// stop sending until every owed result has come back
	task automatic wait_until_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// mostly sane dates, some bad months and days, years biased to the top
	task automatic drive_random();
		logic [4:0]  d;
		logic [3:0]  m;
		logic [13:0] y;
		logic [15:0] n;
		int          pick;
		m = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 12));
		d = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 31));
		pick = $urandom_range(0, 9);
		if (pick < 4)
			y = 14'($urandom_range(0, 16383));
		else if (pick < 7)
			y = 14'(16383 - $urandom_range(0, 250));
		else
			y = 14'($urandom_range(1890, 2110));
		pick = $urandom_range(0, 9);
		if (pick < 4)
			n = 16'($urandom_range(0, 60));
		else if (pick < 7)
			n = 16'($urandom_range(0, 1500));
		else if (pick < 9)
			n = 16'($urandom_range(0, 65535));
		else
			n = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
		drive_item(d, m, y, n);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		start_day = '0;
		start_month = '0;
		start_year = '0;
		days_to_add = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, leap years, saturation, bad months and days
		drive_item(5'd1, 4'd1, 14'd0, 16'd0);
		drive_item(5'd31, 4'd12, 14'd16383, 16'hFFFF);
		drive_item(5'd28, 4'd2, 14'd2024, 16'd1);
		drive_item(5'd28, 4'd2, 14'd2023, 16'd1);
		drive_item(5'd31, 4'd12, 14'd16383, 16'd1);
		drive_item(5'd31, 4'd12, 14'd16382, 16'd1);
		drive_item(5'd0, 4'd0, 14'd100, 16'd0);
		drive_item(5'd0, 4'd5, 14'd100, 16'd0);
		drive_item(5'd0, 4'd13, 14'd100, 16'd0);
		drive_item(5'd5, 4'd0, 14'd2000, 16'd0);
		drive_item(5'd1, 4'd13, 14'd2000, 16'd0);
		drive_item(5'd31, 4'd15, 14'd2000, 16'd100);
		drive_item(5'd3, 4'd14, 14'd16383, 16'd0);
		drive_item(5'd31, 4'd4, 14'd1999, 16'd0);
		drive_item(5'd31, 4'd2, 14'd2023, 16'd0);
		drive_item(5'd1, 4'd1, 14'd0, 16'hFFFF);
		drive_item(5'd31, 4'd15, 14'd16383, 16'hFFFF);
		drive_item(5'd15, 4'd6, 14'd1000, 16'd365);
		drive_item(5'd29, 4'd2, 14'd16380, 16'd1461);
		drive_item(5'd0, 4'd1, 14'd8191, 16'd1);
		drive_item(5'd30, 4'd11, 14'd5461, 16'h5555);
		drive_item(5'd10, 4'd10, 14'd10922, 16'hAAAA);
		wait_until_drained();

		// random bursts with random gaps, one full drain half way
		sent = 0;
		drained = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				drive_random();
				sent++;
			end
			if (!drained && sent >= RANDOM_ITEMS / 2) begin
				wait_until_drained();
				drained = 1'b1;
			end else if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end

		wait_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
